>>> rtl/b64e_pkg.sv
// Shared types, constants and the sextet-to-ASCII mapping for the base64url encoder.
// No dependencies; every other file of the encoder imports this package.
`default_nettype none

package b64e_pkg;

  // Default depth of the job queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte position within the current 3-byte group, one-hot.
  typedef enum logic [2:0] {
    PHASE_0 = 3'b001,
    PHASE_1 = 3'b010,
    PHASE_2 = 3'b100
  } phase_t;

  // One classified byte: the one or two sextets that it produces.
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic       two;    // sextet1 is to be emitted as well
    logic       last;   // the final emitted sextet of this job ends the message
  } job_t;

  // Status of the job queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Maps a 6-bit value onto the base64url alphabet.
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
    logic [7:0] code;
    code = 8'd0;
    if (s inside {[6'd0:6'd25]}) begin
      code = 8'd65 + {2'b00, s};
    end else if (s inside {[6'd26:6'd51]}) begin
      code = 8'd71 + {2'b00, s};
    end else if (s inside {[6'd52:6'd61]}) begin
      code = {2'b00, s} - 8'd4;
    end else if (s == 6'd62) begin
      code = 8'd45;
    end else begin
      code = 8'd95;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/base64url_stream_encoder.sv
// Top level of the unpadded base64url stream encoder: front classifier, job queue
// and character emitter. Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Usage. Message bytes enter as words on a queue-style input: data_byte with
// end_of_message set on the final byte, taken at a clock edge where push is high
// and full is low. Characters leave on a queue-style output: out_char (ASCII of
// A-Z a-z 0-9 - _) and last_char, valid while empty is low and taken at an edge
// where pop is high. last_char marks the final character of each message; no
// padding is produced. A message must hold at least one byte.
//
// Each byte's job is written into the job queue, and its characters are then loaded
// into the output register. The output register sends one character per cycle while
// the receiver keeps pop high; a byte gives one or two characters, and a full stream
// runs at four characters per three bytes.
// The job queue (QUEUE_DEPTH entries) lets the front keep taking bytes while a
// finished character waits; when the receiver stalls, the queue fills and full
// rises until pop resumes. Reset (rst, synchronous) empties the queue and output
// and returns the encoder to the start of a 3-byte group.
`default_nettype none

module base64url_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire  [7:0] data_byte,
  input  wire        end_of_message,
  input  wire        push,
  output logic       full,
  output logic [7:0] out_char,
  output logic       last_char,
  output logic       empty,
  input  wire        pop
);
  import b64e_pkg::*;

  job_t          new_job;
  job_t          head_job;
  queue_status_t q_status;
  logic          accept;
  logic          q_pop;
  logic          at_group_start;

  // A byte is taken whenever push is high and the queue has room for its job.
  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (new_job),
    .at_group_start (at_group_start)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_job (new_job),
    .rd_en  (q_pop),
    .rd_job (head_job),
    .status (q_status)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_char  (out_char),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop)
  );

  // Every character shown belongs to the base64url alphabet.
  a_charset : assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((out_char >= 8'd65 && out_char <= 8'd90) ||
                (out_char >= 8'd97 && out_char <= 8'd122) ||
                (out_char >= 8'd48 && out_char <= 8'd57) ||
                out_char == 8'd45 || out_char == 8'd95))
    else $error("output character outside the base64url alphabet");

  // The queue is never reported full and empty at once.
  a_queue_status : assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("job queue reports full and empty together");

  // The final byte of a message returns the encoder to the start of a group.
  a_group_restart : assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_message) |=> at_group_start)
    else $error("encoder not at group start after a final byte");

endmodule

`default_nettype wire

>>> rtl/b64e_front.sv
// Front part of the base64url encoder: tracks the group phase and leftover bits
// and turns each accepted byte into a job of one or two sextets. Uses b64e_pkg.
`default_nettype none

module b64e_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire  [7:0]          data_byte,
  input  wire                 end_of_message,
  output b64e_pkg::job_t      job,
  output logic                at_group_start
);
  import b64e_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;

  always_comb begin
    job        = '0;
    phase_next = phase;
    carry_next = carry;
    case (phase)
      PHASE_1: begin
        job.sextet0 = {carry[1:0], data_byte[7:4]};
        job.sextet1 = {data_byte[3:0], 2'b00};
        job.two     = end_of_message;
        job.last    = end_of_message;
        carry_next  = data_byte[3:0];
        phase_next  = PHASE_2;
      end
      PHASE_2: begin
        job.sextet0 = {carry, data_byte[7:6]};
        job.sextet1 = data_byte[5:0];
        job.two     = 1'b1;
        job.last    = end_of_message;
        carry_next  = 4'd0;
        phase_next  = PHASE_0;
      end
      default: begin
        // The start of a group; any unexpected code is treated the same way.
        job.sextet0 = data_byte[7:2];
        job.sextet1 = {data_byte[1:0], 4'b0000};
        job.two     = end_of_message;
        job.last    = end_of_message;
        carry_next  = {2'b00, data_byte[1:0]};
        phase_next  = PHASE_1;
      end
    endcase
    if (end_of_message) begin
      carry_next = 4'd0;
      phase_next = PHASE_0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_0;
      carry <= 4'd0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

  assign at_group_start = (phase == PHASE_0);

endmodule

`default_nettype wire

>>> rtl/b64e_queue.sv
// Short job queue that decouples the front and back parts of the encoder.
// Uses the job and status types of b64e_pkg.
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       wr_en,
  input  b64e_pkg::job_t            wr_job,
  input  wire                       rd_en,
  output b64e_pkg::job_t            rd_job,
  output b64e_pkg::queue_status_t   status
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign status.full  = (count == FullCnt);
  assign status.empty = (count == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/b64e_back.sv
// Back part of the base64url encoder: emits the sextets of each queued job one
// character per cycle while pop is high, via an output register. Uses b64e_pkg.
`default_nettype none

module b64e_back (
  input  wire                      clk,
  input  wire                      rst,
  input  b64e_pkg::job_t           head_job,
  input  b64e_pkg::queue_status_t  q_status,
  output logic                     q_pop,
  output logic [7:0]               out_char,
  output logic                     last_char,
  output logic                     empty,
  input  wire                      pop
);
  import b64e_pkg::*;

  logic       out_valid;
  logic       second;     // the next character taken is the job's second one
  logic       load;
  logic [5:0] sextet;
  logic       is_final;

  assign load     = (!out_valid || pop) && !q_status.empty;
  assign sextet   = second ? head_job.sextet1 : head_job.sextet0;
  assign is_final = second || !head_job.two;
  assign q_pop    = load && is_final;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !is_final;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= sextet_to_ascii(sextet);
      last_char <= is_final && head_job.last;
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the unpadded base64url stream encoder (base64url_stream_encoder).
// Needs only the encoder RTL and its package; it predicts every character with its own
// bit-level model of the encoder and checks each output word against it.
`default_nettype none

module testbench;

  // Every byte gives one or two characters. The characters of a byte pass through the
  // job queue and the output register, so a short settle at the end is plenty.
  localparam int unsigned MAX_GAP        = 16;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned TARGET_BYTES   = 1950;
  localparam int unsigned PRINT_LIMIT    = 100;

  // Position of the next byte within its 3-byte group. A group of 24 bits
  // becomes four characters.
  typedef enum logic [1:0] {
    GROUP_BYTE0,
    GROUP_BYTE1,
    GROUP_BYTE2
  } group_pos_t;

  // One predicted output word.
  typedef struct {
    logic [7:0] code;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_message = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  wire        full;
  wire  [7:0] out_char;
  wire        last_char;
  wire        empty;

  // Sextet value n maps onto character n of this string.
  string b64url_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // Encoder state as the prediction sees it.
  group_pos_t group_pos = GROUP_BYTE0;
  logic [3:0] carry_bits = 4'd0;

  // Characters that accepted bytes have produced and the encoder has not yet sent.
  enc_char_t  pending_chars[$];

  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;

  // Idle controls: when set, the side waits a random gap of zero up to MAX_GAP before each word.
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  // Asks the receiver to keep pop low for a long stretch so that the encoder fills up.
  bit hold_request = 1'b0;

  base64url_stream_encoder uut (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .out_char       (out_char),
    .last_char      (last_char),
    .empty          (empty),
    .pop            (pop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_char(input logic [5:0] sextet, input logic last);
    enc_char_t c;
    c.code = b64url_alphabet[sextet];
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  // Works out the characters of one accepted byte and advances the group state.
  // The first byte of a group gives its top six bits and keeps two; the second
  // gives the two kept bits with its top four and keeps four; the third closes
  // the group with two characters. On the final byte of a message the kept bits
  // are flushed, shifted left, so the final byte always ends in exactly two
  // characters, the second marked last, and the next message starts a new group.
  function automatic void predict_chars(input logic [7:0] b, input logic eom);
    case (group_pos)
      GROUP_BYTE1: begin
        queue_char({carry_bits[1:0], b[7:4]}, 1'b0);
        carry_bits = b[3:0];
        group_pos = GROUP_BYTE2;
        if (eom) begin
          queue_char({carry_bits, 2'b00}, 1'b1);
        end
      end
      GROUP_BYTE2: begin
        queue_char({carry_bits, b[7:6]}, 1'b0);
        queue_char(b[5:0], eom);
        carry_bits = 4'd0;
        group_pos = GROUP_BYTE0;
      end
      default: begin
        queue_char(b[7:2], 1'b0);
        carry_bits = {2'b00, b[1:0]};
        group_pos = GROUP_BYTE1;
        if (eom) begin
          queue_char({b[1:0], 4'b0000}, 1'b1);
        end
      end
    endcase
    if (eom) begin
      group_pos = GROUP_BYTE0;
      carry_bits = 4'd0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side
  // ---------------------------------------------------------------------------

  // Offers one byte and returns at the edge where it is taken. Inputs change only
  // at rising edges. On return push stays high, so a follow-on byte with no gap is
  // offered on the very next cycle without lowering push in between.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    end_of_message <= eom;
    // Values read right after the edge are those the encoder saw at that edge.
    do @(posedge clk); while (full);
    predict_chars(b, eom);
    bytes_sent++;
  endtask

  // A message of random bytes; only its last byte carries end_of_message.
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side
  // ---------------------------------------------------------------------------

  // Draws a random stall before each word while receiver_idle is set. On request it
  // holds pop low for a long, counted stretch while the sender keeps pushing, so the
  // encoder's queue fills and full rises.
  initial begin : receiver
    int unsigned gap;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  // Every word taken from the encoder is compared with the oldest prediction.
  always @(posedge clk) begin : check_output
    enc_char_t exp_char;
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h (last %0b) with no byte behind it",
                                  out_char, last_char));
      end else begin
        exp_char = pending_chars.pop_front();
        if (out_char !== exp_char.code) begin
          report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h",
                                    out_char, exp_char.code));
        end
        if (last_char !== exp_char.last) begin
          report_mismatch($sformatf("last_char %0b, predicted %0b on out_char 0x%02h",
                                    last_char, exp_char.last, exp_char.code));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Messages that end at each position of a group, with all-zero and all-one bytes,
  // and bytes that give the two punctuation characters of the alphabet.
  task automatic test_directed;
    send_byte(8'h00, 1'b1);               // ends on the first byte of a group
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b1);               // gives '-' and then a flushed character
    send_byte(8'h00, 1'b0);               // ends on the second byte of a group
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);               // ends on the third byte, no flush needed
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);               // all '_'
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);               // all '-'
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hAA, 1'b0);               // alternating bits across two groups
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // Back-to-back bytes and an always-ready receiver: the encoder runs at full rate.
  task automatic test_full_rate;
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    while (bytes_sent < 180) begin
      send_message($urandom_range(1, 12));
    end
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // The receiver stops for a long stretch while bytes keep coming.
  task automatic test_back_pressure;
    sender_idle = 1'b0;
    hold_request = 1'b1;
    send_message(32);
    sender_idle = 1'b1;
  endtask

  // Random messages, mostly short, some longer, with idling on each side that is
  // turned off now and then so that both gaps and full-rate stretches occur.
  task automatic test_random_messages;
    while (bytes_sent < TARGET_BYTES) begin
      sender_idle = ($urandom_range(0, 7) != 0);
      receiver_idle = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 9) < 8) begin
        send_message($urandom_range(1, 6));
      end else begin
        send_message($urandom_range(7, 30));
      end
    end
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed;
    test_full_rate;
    test_back_pressure;
    test_random_messages;
    push <= 1'b0;

    // Drain: every predicted character must arrive, then nothing more may follow.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: a run that hangs is reported as failed and ended.
  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire
